// ===== design/bpmc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpmc_pkg
// Shared types and constants of the bad pixel median corrector.
// ----------------------------------------------------------------------------
package bpmc_pkg;

	// default build values
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 16;

	// fixed field widths
	localparam int FIELD_BITS    = 16;
	localparam int FW_BITS       = 11;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	// register reset values
	localparam logic [FW_BITS-1:0]    FW_RESET    = 11'd640;
	localparam logic [FIELD_BITS-1:0] FH_RESET    = 16'd512;
	localparam logic [FIELD_BITS-1:0] FLOOR_RESET = 16'd0;

	// jobs allowed between classification and output (queue depth too)
	localparam int JOB_SLOTS = 8;

	// 3x3 window taps, row major, center in the middle
	localparam int TAPS       = 9;
	localparam int CENTER_TAP = 4;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_FLOOR_VALUE  = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KIND_PIXEL = 1'b0,
		KIND_FLUSH = 1'b1
	} item_kind_t;

	// one output to be produced: where its center sits and the frame geometry
	// hist: outputs issued before this one since reset (saturating)
	typedef struct packed {
		logic [FIELD_BITS-1:0] base;
		logic [FIELD_BITS-1:0] pend;
		logic [FIELD_BITS-1:0] hist;
		logic [FIELD_BITS-1:0] row;
		logic [FIELD_BITS-1:0] col;
		logic [FIELD_BITS-1:0] width;
		logic [FIELD_BITS-1:0] height;
		logic                  last;
	} job_t;

endpackage

// ===== design/bpmc_if.sv =====
// ----------------------------------------------------------------------------
// bpmc_in_if / bpmc_out_if
// Valid/ready channels for pixel beats in and corrected pixel beats out.
// ----------------------------------------------------------------------------
interface bpmc_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] pixel_in;
	logic        is_bad;

	modport source (output valid, kind, pixel_in, is_bad, input ready);
	modport sink   (input valid, kind, pixel_in, is_bad, output ready);
endinterface

interface bpmc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel_out;
	logic        frame_last;

	modport source (output valid, pixel_out, frame_last, input ready);
	modport sink   (input valid, pixel_out, frame_last, output ready);
endinterface

// ===== design/bpmc_front.sv =====
// ----------------------------------------------------------------------------
// bpmc_front
// Accepts beats, writes pixels to the ring, decides which beat releases an
// output and issues a job for it with the output position.
// ----------------------------------------------------------------------------
module bpmc_front #(
	parameter int MAX_WIDTH  = bpmc_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = bpmc_pkg::PIXEL_BITS_DEF,
	parameter int RING_DEPTH = 2 * bpmc_pkg::MAX_WIDTH_DEF + 4 + 2 * bpmc_pkg::JOB_SLOTS,
	localparam int AW = $clog2(RING_DEPTH),
	localparam int DW = PIXEL_BITS + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bpmc_in_if.sink               pix_in,
	input  logic [10:0]           frame_width,
	input  logic [15:0]           frame_height,
	input  logic                  out_beat,
	output logic                  job_push,
	output bpmc_pkg::job_t        job,
	output logic                  mem_we,
	output logic [AW-1:0]         mem_wa,
	output logic [DW-1:0]         mem_wd
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PW = $clog2(MAX_WIDTH + 3);
	localparam int IW = $clog2(bpmc_pkg::JOB_SLOTS + 1);

	logic [AW-1:0] wr_q, base_q;
	logic [PW-1:0] pend_q, pend_d;
	logic [CW-1:0] col_q;
	logic [15:0]   row_q;
	logic [15:0]   hist_q;
	logic [IW-1:0] inflight_q;

	logic [15:0] w_eff, h_eff, fw16, pend16, pinc;
	logic        is_flush, emit, fire;

	// effective geometry
	assign fw16 = 16'(frame_width);
	always_comb begin
		if (frame_width == '0) begin
			w_eff = 16'd1;
		end else if (fw16 > 16'(MAX_WIDTH)) begin
			w_eff = 16'(MAX_WIDTH);
		end else begin
			w_eff = fw16;
		end
	end
	assign h_eff = (frame_height == '0) ? 16'd1 : frame_height;

	// classify the beat
	assign is_flush = (pix_in.kind == bpmc_pkg::KIND_FLUSH);
	assign pend16   = 16'(pend_q);
	assign pinc     = pend16 + 16'd1;
	assign emit     = is_flush ? (pend_q != '0) : ({1'b0, pinc} > ({1'b0, w_eff} + 17'd1));
	assign fire     = pix_in.valid && pix_in.ready;
	assign pix_in.ready = (inflight_q < IW'(bpmc_pkg::JOB_SLOTS));
	assign job_push = fire && emit;

	// ring write
	assign mem_we = fire && !is_flush;
	assign mem_wa = wr_q;
	assign mem_wd = {pix_in.is_bad, pix_in.pixel_in[PIXEL_BITS-1:0]};

	// job contents
	always_comb begin
		job.base   = 16'(base_q);
		job.pend   = is_flush ? pend16 : pinc;
		job.hist   = hist_q;
		job.row    = row_q;
		job.col    = 16'(col_q);
		job.width  = w_eff;
		job.height = h_eff;
		job.last   = (row_q == h_eff - 16'd1) && (16'(col_q) == w_eff - 16'd1);
	end

	// pending count update
	always_comb begin
		pend_d = pend_q;
		if (fire) begin
			if (is_flush) begin
				if (emit) pend_d = pend_q - PW'(1);
			end else if (!emit) begin
				pend_d = pend_q + PW'(1);
			end
		end
	end

	// pointers, output position and count of issued outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			base_q <= '0;
			pend_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
			hist_q <= '0;
		end else begin
			pend_q <= pend_d;
			if (mem_we) begin
				wr_q <= (wr_q == AW'(RING_DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (job_push) begin
				base_q <= (base_q == AW'(RING_DEPTH - 1)) ? '0 : base_q + AW'(1);
				if (hist_q != '1) hist_q <= hist_q + 16'd1;
				if (({1'b0, 16'(col_q)} + 17'd1) >= {1'b0, w_eff}) begin
					col_q <= '0;
					row_q <= (({1'b0, row_q} + 17'd1) >= {1'b0, h_eff}) ? '0 : row_q + 16'd1;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	// jobs issued but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			case ({job_push, out_beat})
				2'b10:   inflight_q <= inflight_q + IW'(1);
				2'b01:   inflight_q <= inflight_q - IW'(1);
				default: inflight_q <= inflight_q;
			endcase
		end
	end

endmodule

// ===== design/bpmc_queue.sv =====
// ----------------------------------------------------------------------------
// bpmc_queue
// Small job FIFO between front and back.
// ----------------------------------------------------------------------------
module bpmc_queue #(
	parameter int DEPTH = bpmc_pkg::JOB_SLOTS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bpmc_pkg::job_t din,
	input  logic           pop,
	output bpmc_pkg::job_t dout,
	output logic           not_empty
);

	localparam int PTW = $clog2(DEPTH);
	localparam int CNW = $clog2(DEPTH + 1);

	bpmc_pkg::job_t slot_q [DEPTH];
	logic [PTW-1:0] wp_q, rp_q;
	logic [CNW-1:0] cnt_q;
	logic           do_pop;

	assign not_empty = (cnt_q != '0);
	assign do_pop    = pop && not_empty;
	assign dout      = slot_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= din;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PTW'(DEPTH - 1)) ? '0 : wp_q + PTW'(1);
			if (do_pop) rp_q <= (rp_q == PTW'(DEPTH - 1)) ? '0 : rp_q + PTW'(1);
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + CNW'(1);
				2'b01:   cnt_q <= cnt_q - CNW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/bpmc_back.sv =====
// ----------------------------------------------------------------------------
// bpmc_back
// Runs jobs: window addresses and masks, ring reads, rank matrix, median
// select and floor clamp, into the output register.
// ----------------------------------------------------------------------------
module bpmc_back #(
	parameter int PIXEL_BITS = bpmc_pkg::PIXEL_BITS_DEF,
	parameter int RING_DEPTH = 2 * bpmc_pkg::MAX_WIDTH_DEF + 4 + 2 * bpmc_pkg::JOB_SLOTS,
	localparam int AW = $clog2(RING_DEPTH),
	localparam int DW = PIXEL_BITS + 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  bpmc_pkg::job_t job,
	output logic           job_pop,
	input  logic           mem_we,
	input  logic [AW-1:0]  mem_wa,
	input  logic [DW-1:0]  mem_wd,
	input  logic [15:0]    floor_value,
	bpmc_out_if.source     pix_out
);

	localparam int T     = bpmc_pkg::TAPS;
	localparam int C     = bpmc_pkg::CENTER_TAP;
	localparam int NCOPY = (T + 1) / 2;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [AW-1:0]         addr_d [T];
	logic [T-1:0]          mask_d, zero_d;
	logic [AW-1:0]         addr_s1 [T];
	logic [T-1:0]          mask_s1, mask_s2, mask_s3;
	logic [T-1:0]          zero_s1, zero_s2;
	logic                  last_s1, last_s2, last_s3, last_s4;
	logic [DW-1:0]         data_s2 [T];
	logic [T-1:0]          before_d [T];
	logic [T-1:0]          before_s3 [T];
	logic [PIXEL_BITS-1:0] val_s3 [T];
	logic                  bad_s3;
	logic [15:0]           pixel_out_s4;

	logic [16:0] row_x, h_x, col_x, w_x, pend_x;
	logic [2:0]  row_ok, col_ok;

	logic [3:0]            n_cnt, half, rank;
	logic [PIXEL_BITS-1:0] med, pick;
	logic [15:0]           val16, res16;

	assign en      = !v_s4 || pix_out.ready;
	assign job_pop = en && job_valid;

	// stage 1: neighbor addresses and which neighbors count
	assign row_x  = {1'b0, job.row};
	assign h_x    = {1'b0, job.height};
	assign col_x  = {1'b0, job.col};
	assign w_x    = {1'b0, job.width};
	assign pend_x = {1'b0, job.pend};

	assign row_ok[0] = (job.row != '0) && (row_x <= h_x);
	assign row_ok[1] = (row_x < h_x);
	assign row_ok[2] = ((row_x + 17'd1) < h_x);
	assign col_ok[0] = (job.col != '0) && (col_x <= w_x);
	assign col_ok[1] = (col_x < w_x);
	assign col_ok[2] = ((col_x + 17'd1) < w_x);

	always_comb begin
		logic signed [18:0] wsg, rsg, offs, sum, wrapped, hsum;
		logic               arrived;
		int                 k;
		wsg = signed'({3'b0, job.width});
		rsg = signed'(19'(RING_DEPTH));
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				k = a * 3 + b;
				// only neighbors already written may take part
				case (a)
					0: begin
						offs    = -wsg;
						arrived = 1'b1;
					end
					1: begin
						offs    = '0;
						arrived = (b < 2) ? 1'b1 : (pend_x > 17'd1);
					end
					default: begin
						offs    = wsg;
						arrived = ((w_x + 17'(b)) < (pend_x + 17'd1));
					end
				endcase
				sum = signed'({3'b0, job.base}) + offs + 19'(b - 1);
				if (sum < 0) begin
					wrapped = sum + rsg;
				end else if (sum >= rsg) begin
					wrapped = sum - rsg;
				end else begin
					wrapped = sum;
				end
				// taps before the first pixel since reset hold zero
				hsum      = signed'({3'b0, job.hist}) + offs + 19'(b - 1);
				zero_d[k] = (hsum < 0);
				addr_d[k] = wrapped[AW-1:0];
				mask_d[k] = row_ok[a] && col_ok[b] && arrived;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			addr_s1 <= addr_d;
			mask_s1 <= mask_d;
			zero_s1 <= zero_d;
			last_s1 <= job.last;
		end
	end

	// stage 2: ring copies, two reads each but the last with one, all written alike
	generate
		for (genvar g = 0; g < NCOPY; g++) begin : g_copy
			logic [DW-1:0] mem [RING_DEPTH];
			logic [DW-1:0] rd0_s2;
			always_ff @(posedge clk) begin
				if (mem_we) mem[mem_wa] <= mem_wd;
				if (en) rd0_s2 <= mem[addr_s1[2 * g]];
			end
			assign data_s2[2 * g] = zero_s2[2 * g] ? '0 : rd0_s2;
			if (2 * g + 1 < T) begin : g_port1
				logic [DW-1:0] rd1_s2;
				always_ff @(posedge clk) begin
					if (en) rd1_s2 <= mem[addr_s1[2 * g + 1]];
				end
				assign data_s2[2 * g + 1] = zero_s2[2 * g + 1] ? '0 : rd1_s2;
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			mask_s2 <= mask_s1;
			zero_s2 <= zero_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: pairwise order, ties broken by tap index
	always_comb begin
		for (int i = 0; i < T; i++) begin
			for (int j = 0; j < T; j++) begin
				if (j < i) begin
					before_d[i][j] = data_s2[j][PIXEL_BITS-1:0] <= data_s2[i][PIXEL_BITS-1:0];
				end else if (j > i) begin
					before_d[i][j] = data_s2[j][PIXEL_BITS-1:0] < data_s2[i][PIXEL_BITS-1:0];
				end else begin
					before_d[i][j] = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			before_s3 <= before_d;
			for (int i = 0; i < T; i++) val_s3[i] <= data_s2[i][PIXEL_BITS-1:0];
			bad_s3  <= data_s2[C][DW-1];
			mask_s3 <= mask_s2;
			last_s3 <= last_s2;
		end
	end

	// stage 4: pick the tap whose rank is count/2, then the floor
	assign n_cnt = 4'($countones(mask_s3));
	assign half  = n_cnt >> 1;

	always_comb begin
		med  = '0;
		rank = '0;
		pick = '0;
		for (int i = 0; i < T; i++) begin
			rank = 4'($countones(before_s3[i] & mask_s3));
			pick = (mask_s3[i] && (rank == half)) ? val_s3[i] : '0;
			med  = med | pick;
		end
	end

	assign val16 = (bad_s3 && (n_cnt != '0)) ? 16'(med) : 16'(val_s3[C]);
	assign res16 = ((floor_value != '0) && (val16 < floor_value)) ? floor_value : val16;

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_out_s4 <= res16;
			last_s4      <= last_s3;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= job_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign pix_out.valid      = v_s4;
	assign pix_out.pixel_out  = pixel_out_s4;
	assign pix_out.frame_last = last_s4;

endmodule

// ===== design/bad_pixel_median_correct_core.sv =====
// ----------------------------------------------------------------------------
// bad_pixel_median_correct_core
// Streaming 3x3 median replacement of flagged pixels with a floor clamp.
// ----------------------------------------------------------------------------
// Takes one beat per clock and gives one beat per clock in steady state while
// the sink stays ready. A pixel beat is written to a ring of recent pixels;
// once more than frame_width+1 pixels wait, each pixel beat releases the
// oldest waiting output, and a flush beat releases one on its own. The
// released job passes through the queue, address stage, ring read, rank
// matrix, then select and clamp into the output register. Up to JOB_SLOTS
// outputs may be in flight; ready drops when they are all taken, so a
// stalled sink stops the input after that many releases. The ring is read at
// nine taps per output from five copies with two read ports each but the
// last, which has one. The ring has no reset: taps that would reach before
// the first pixel since reset read as zero, judged from a saturating count of
// issued outputs, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module bad_pixel_median_correct_core #(
	parameter int MAX_WIDTH  = bpmc_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = bpmc_pkg::PIXEL_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	bpmc_in_if.sink                            pix_in,
	bpmc_out_if.source                         pix_out,
	input  logic                               cfg_wen,
	input  logic [bpmc_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [bpmc_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	localparam int RING_DEPTH = 2 * MAX_WIDTH + 4 + 2 * bpmc_pkg::JOB_SLOTS;
	localparam int AW = $clog2(RING_DEPTH);
	localparam int DW = PIXEL_BITS + 1;

	logic [bpmc_pkg::FW_BITS-1:0] frame_width_q;
	logic [15:0]                  frame_height_q, floor_value_q;

	logic           job_push, job_pop, job_valid, out_beat;
	bpmc_pkg::job_t job_in, job_out;
	logic           mem_we;
	logic [AW-1:0]  mem_wa;
	logic [DW-1:0]  mem_wd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= bpmc_pkg::FW_RESET;
			frame_height_q <= bpmc_pkg::FH_RESET;
			floor_value_q  <= bpmc_pkg::FLOOR_RESET;
		end else if (cfg_wen) begin
			case (cfg_idx)
				bpmc_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[bpmc_pkg::FW_BITS-1:0];
				bpmc_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				bpmc_pkg::REG_FLOOR_VALUE:  floor_value_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_beat = pix_out.valid && pix_out.ready;

	bpmc_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS),
		.RING_DEPTH (RING_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_in       (pix_in),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.out_beat     (out_beat),
		.job_push     (job_push),
		.job          (job_in),
		.mem_we       (mem_we),
		.mem_wa       (mem_wa),
		.mem_wd       (mem_wd)
	);

	bpmc_queue #(
		.DEPTH (bpmc_pkg::JOB_SLOTS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.din       (job_in),
		.pop       (job_pop),
		.dout      (job_out),
		.not_empty (job_valid)
	);

	bpmc_back #(
		.PIXEL_BITS (PIXEL_BITS),
		.RING_DEPTH (RING_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job         (job_out),
		.job_pop     (job_pop),
		.mem_we      (mem_we),
		.mem_wa      (mem_wa),
		.mem_wd      (mem_wd),
		.floor_value (floor_value_q),
		.pix_out     (pix_out)
	);

endmodule

// ===== design/bpmc_checker.sv =====
// ----------------------------------------------------------------------------
// bpmc_checker
// Port-level checks of the corrector, bound to the top level.
// ----------------------------------------------------------------------------
module bpmc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] pixel_out,
	input logic        frame_last
);

	logic        in_beat, out_beat;
	logic [15:0] owed_q;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// input beats not yet answered by an output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= '0;
		end else begin
			case ({in_beat, out_beat})
				2'b10:   owed_q <= owed_q + 16'd1;
				2'b01:   owed_q <= owed_q - 16'd1;
				default: owed_q <= owed_q;
			endcase
		end
	end

	// at most one output per input beat
	a_no_extra_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> (owed_q != '0))
		else $error("output beat without a pending input beat");

	// with nothing owed the input side must be open
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(owed_q == '0) |-> in_ready)
		else $error("input not ready while nothing is in flight");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("output valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(pixel_out) && $stable(frame_last)))
		else $error("output payload changed while stalled");

endmodule

bind bad_pixel_median_correct_core bpmc_checker u_bpmc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (pix_in.valid),
	.in_ready   (pix_in.ready),
	.out_valid  (pix_out.valid),
	.out_ready  (pix_out.ready),
	.pixel_out  (pix_out.pixel_out),
	.frame_last (pix_out.frame_last)
);
